// File: rtl/core/cdt_pkg.sv
// Shared widths, calendar constants and the sideband type for the date-to-ticks pipeline.
// Used by cdt_tick_mul and civil_datetime_to_ticks; depends on nothing else.
`timescale 1ns / 1ps

package cdt_pkg;

   // Field and result widths.
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_IN_W = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int MILLI_W  = 10;
   localparam int DAY_W    = 22;
   localparam int WDAY_W   = 3;
   localparam int TICK_W   = 62;

   // Internal widths: time of day in ms, total ms, and the split of ms for the tick multiply.
   localparam int TOD_W    = 27;
   localparam int MS_W     = 49;
   localparam int MS_LO_W  = 25;
   localparam int MS_HI_W  = MS_W - MS_LO_W;
   localparam int CUM_W    = 9;
   localparam int Q100_W   = 8;
   localparam int YPROD_W  = 25;
   localparam int WPROD_W  = 42;
   localparam int Q7_W     = 20;
   localparam int REM7_W   = 4;
   localparam int SUM_W    = 64;

   // Range limits.
   localparam logic [YEAR_W-1:0]   YEAR_MAX   = 14'd9999;
   localparam logic [MONTH_W-1:0]  MONTH_MAX  = 4'd12;
   localparam logic [MONTH_W-1:0]  FEB        = 4'd2;
   localparam logic [DAY_IN_W-1:0] LEAP_FEB_LEN = 5'd29;
   localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
   localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
   localparam logic [SECOND_W-1:0] SECOND_MAX = 6'd59;
   localparam logic [MILLI_W-1:0]  MILLI_MAX  = 10'd999;

   // Calendar and time scale constants.
   localparam logic [6:0]  YEARS_PER_CENTURY = 7'd100;
   localparam logic [8:0]  DAYS_PER_YEAR     = 9'd365;
   localparam logic [2:0]  DAYS_PER_WEEK     = 3'd7;
   localparam logic [26:0] MS_PER_DAY        = 27'd86400000;
   localparam logic [21:0] MS_PER_HOUR       = 22'd3600000;
   localparam logic [15:0] MS_PER_MINUTE     = 16'd60000;
   localparam logic [9:0]  MS_PER_SECOND     = 10'd1000;

   // Reciprocals: floor(x / 25) = (x * 5243) >> 17 for x below 4096,
   // and (d * 599186) >> 22 undershoots d / 7 by at most one below 2^22.
   localparam logic [12:0] RECIP_25        = 13'd5243;
   localparam int          RECIP_25_SHIFT  = 17;
   localparam logic [19:0] RECIP_7         = 20'd599186;
   localparam int          RECIP_7_SHIFT   = 22;

   // Sideband that rides along with the millisecond count through the tick multiply.
   typedef struct packed {
      logic              is_valid;
      logic [DAY_W-1:0]  day_count;
      logic [WDAY_W-1:0] weekday;
   } cdt_side_type;

   // Days before the first of the given month in a common year.
   function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] month);
      logic [CUM_W-1:0] days;
      case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   // Length of the given month in a common year; zero for a month number that means nothing.
   function automatic logic [DAY_IN_W-1:0] month_len(input logic [MONTH_W-1:0] month);
      logic [DAY_IN_W-1:0] len;
      case (month)
         4'd1:    len = 5'd31;
         4'd2:    len = 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// File: rtl/core/civil_datetime_to_ticks.sv
// Top level: checks a Gregorian date and time of day and converts it to day and tick counts.
// Depends on cdt_pkg and instantiates cdt_tick_mul.
`timescale 1ns / 1ps

// The block takes one item in every clock cycle: busy is high only during and just after
// reset, so an item is taken at every edge where start is high and busy is low. Each result
// appears on the rsp_ ports for exactly one cycle, marked by rsp_strobe, and results come
// out in the order their items went in. The six-stage pipeline holds the range checks and
// century reciprocal, the leap rule and month check, the day sum, the day to millisecond and
// weekday reciprocal products, and the two-part multiply by TICKS_PER_MS, whose first part
// also takes the final add with the weekday correction. The receiver cannot stall the block.
// An item with any field out of range gives rsp_is_valid low and zero counts and weekday.
module civil_datetime_to_ticks #(
   parameter int TICKS_PER_MS = 10000
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [cdt_pkg::YEAR_W-1:0]   req_year_in,
   input  logic [cdt_pkg::MONTH_W-1:0]  req_month_in,
   input  logic [cdt_pkg::DAY_IN_W-1:0] req_day_in,
   input  logic [cdt_pkg::HOUR_W-1:0]   req_hour_in,
   input  logic [cdt_pkg::MINUTE_W-1:0] req_minute_in,
   input  logic [cdt_pkg::SECOND_W-1:0] req_second_in,
   input  logic [cdt_pkg::MILLI_W-1:0]  req_milli_in,
   output logic                         rsp_strobe,
   output logic                         rsp_is_valid,
   output logic [cdt_pkg::TICK_W-1:0]   rsp_tick_count,
   output logic [cdt_pkg::DAY_W-1:0]    rsp_day_count,
   output logic [cdt_pkg::WDAY_W-1:0]   rsp_weekday
);

   localparam int LATENCY = 6;

   logic busy_ff;
   logic accept;

   // Stage 1 signals.
   logic                          range_ok_in;
   logic [cdt_pkg::YPROD_W-1:0]   yprod_in;
   logic [cdt_pkg::TOD_W-1:0]     tod_in;
   logic                          v1_ff, rok1_ff;
   logic [cdt_pkg::YEAR_W-1:0]    year1_ff;
   logic [cdt_pkg::MONTH_W-1:0]   month1_ff;
   logic [cdt_pkg::DAY_IN_W-1:0]  day1_ff;
   logic [cdt_pkg::YPROD_W-1:0]   yprod1_ff;
   logic [cdt_pkg::TOD_W-1:0]     tod1_ff;

   // Stage 2 signals.
   logic [cdt_pkg::Q100_W-1:0]    q100;
   logic [cdt_pkg::YEAR_W-1:0]    cent_base;
   logic                          is_cent, leap;
   logic [cdt_pkg::DAY_IN_W-1:0]  mlen;
   logic                          ok2_in, adj2_in;
   logic [cdt_pkg::YEAR_W-1:0]    yb2_in;
   logic [cdt_pkg::Q100_W-1:0]    qyb2_in;
   logic                          v2_ff, ok2_ff, adj2_ff;
   logic [cdt_pkg::YEAR_W-1:0]    yb2_ff;
   logic [cdt_pkg::Q100_W-1:0]    qyb2_ff;
   logic [cdt_pkg::MONTH_W-1:0]   month2_ff;
   logic [cdt_pkg::DAY_IN_W-1:0]  day2_ff;
   logic [cdt_pkg::TOD_W-1:0]     tod2_ff;

   // Stage 3 signals.
   logic [cdt_pkg::DAY_W-1:0]     days3_in;
   logic                          v3_ff, ok3_ff;
   logic [cdt_pkg::DAY_W-1:0]     days3_ff;
   logic [cdt_pkg::TOD_W-1:0]     tod3_ff;

   // Stage 4 signals.
   logic [cdt_pkg::MS_W-1:0]      dms4_in;
   logic [cdt_pkg::WPROD_W-1:0]   wprod4_in;
   logic                          v4_ff, ok4_ff;
   logic [cdt_pkg::DAY_W-1:0]     days4_ff;
   logic [cdt_pkg::TOD_W-1:0]     tod4_ff;
   logic [cdt_pkg::MS_W-1:0]      dms4_ff;
   logic [cdt_pkg::WPROD_W-1:0]   wprod4_ff;

   // Stage 5 inputs to the tick multiplier.
   logic [cdt_pkg::MS_W-1:0]      ms_sum;
   logic [cdt_pkg::Q7_W-1:0]      q7;
   logic [cdt_pkg::REM7_W-1:0]    rem7;
   logic [cdt_pkg::WDAY_W-1:0]    wday;
   logic [cdt_pkg::MS_W-1:0]      ms5_in;
   cdt_pkg::cdt_side_type         side5_in;
   cdt_pkg::cdt_side_type         side_out;

   // Busy is held only through reset and the cycle after it.
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // Stage 1: plain range checks, the century reciprocal product and the time of day in ms.
   assign range_ok_in = (req_year_in != '0) && (req_year_in <= cdt_pkg::YEAR_MAX)
                     && (req_month_in != '0) && (req_month_in <= cdt_pkg::MONTH_MAX)
                     && (req_day_in != '0) && (req_hour_in <= cdt_pkg::HOUR_MAX)
                     && (req_minute_in <= cdt_pkg::MINUTE_MAX)
                     && (req_second_in <= cdt_pkg::SECOND_MAX)
                     && (req_milli_in <= cdt_pkg::MILLI_MAX);

   assign yprod_in = cdt_pkg::YPROD_W'(req_year_in[cdt_pkg::YEAR_W-1:2])
                   * cdt_pkg::YPROD_W'(cdt_pkg::RECIP_25);

   assign tod_in = cdt_pkg::TOD_W'(req_hour_in) * cdt_pkg::TOD_W'(cdt_pkg::MS_PER_HOUR)
                 + cdt_pkg::TOD_W'(req_minute_in) * cdt_pkg::TOD_W'(cdt_pkg::MS_PER_MINUTE)
                 + cdt_pkg::TOD_W'(req_second_in) * cdt_pkg::TOD_W'(cdt_pkg::MS_PER_SECOND)
                 + cdt_pkg::TOD_W'(req_milli_in);

   // Stage 2: leap year rule, month length check and the per-year terms of the day count.
   // The quotient of year by 100 also gives that of year minus one, less one on a century.
   assign q100      = yprod1_ff[cdt_pkg::RECIP_25_SHIFT +: cdt_pkg::Q100_W];
   assign cent_base = cdt_pkg::YEAR_W'(q100) * cdt_pkg::YEAR_W'(cdt_pkg::YEARS_PER_CENTURY);
   assign is_cent   = (year1_ff == cent_base);
   assign leap      = (year1_ff[1:0] == 2'b00) && (!is_cent || (q100[1:0] == 2'b00));
   assign mlen      = ((month1_ff == cdt_pkg::FEB) && leap) ? cdt_pkg::LEAP_FEB_LEN
                                                            : cdt_pkg::month_len(month1_ff);
   assign ok2_in    = rok1_ff && (day1_ff <= mlen);
   assign adj2_in   = leap && (month1_ff > cdt_pkg::FEB);
   assign yb2_in    = year1_ff - cdt_pkg::YEAR_W'(1);
   assign qyb2_in   = q100 - cdt_pkg::Q100_W'(is_cent);

   // Stage 3: days since the epoch from the year, leap corrections, month table and day.
   assign days3_in = cdt_pkg::DAY_W'(yb2_ff) * cdt_pkg::DAY_W'(cdt_pkg::DAYS_PER_YEAR)
                   + cdt_pkg::DAY_W'(yb2_ff[cdt_pkg::YEAR_W-1:2])
                   - cdt_pkg::DAY_W'(qyb2_ff)
                   + cdt_pkg::DAY_W'(qyb2_ff[cdt_pkg::Q100_W-1:2])
                   + cdt_pkg::DAY_W'(cdt_pkg::cum_days(month2_ff))
                   + cdt_pkg::DAY_W'(day2_ff)
                   + cdt_pkg::DAY_W'(adj2_ff)
                   - cdt_pkg::DAY_W'(1);

   // Stage 4: days scaled to ms, and the reciprocal product for the weekday.
   assign dms4_in   = cdt_pkg::MS_W'(days3_ff) * cdt_pkg::MS_W'(cdt_pkg::MS_PER_DAY);
   assign wprod4_in = cdt_pkg::WPROD_W'(days3_ff) * cdt_pkg::WPROD_W'(cdt_pkg::RECIP_7);

   // Stage 5: total ms, weekday from the quotient with one correction step, and zeroing
   // of every count for an out-of-range item.
   assign ms_sum = dms4_ff + cdt_pkg::MS_W'(tod4_ff);
   assign q7     = wprod4_ff[cdt_pkg::RECIP_7_SHIFT +: cdt_pkg::Q7_W];
   assign rem7   = cdt_pkg::REM7_W'(days4_ff
                 - cdt_pkg::DAY_W'(q7) * cdt_pkg::DAY_W'(cdt_pkg::DAYS_PER_WEEK));
   assign wday   = (rem7 >= cdt_pkg::REM7_W'(cdt_pkg::DAYS_PER_WEEK))
                 ? cdt_pkg::WDAY_W'(rem7 - cdt_pkg::REM7_W'(cdt_pkg::DAYS_PER_WEEK))
                 : cdt_pkg::WDAY_W'(rem7);

   assign ms5_in             = ok4_ff ? ms_sum : '0;
   assign side5_in.is_valid  = ok4_ff;
   assign side5_in.day_count = ok4_ff ? days4_ff : '0;
   assign side5_in.weekday   = ok4_ff ? wday : '0;

   // Valid bits of the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Payload registers of the pipeline.
   always_ff @(posedge clock) begin
      rok1_ff   <= range_ok_in;
      year1_ff  <= req_year_in;
      month1_ff <= req_month_in;
      day1_ff   <= req_day_in;
      yprod1_ff <= yprod_in;
      tod1_ff   <= tod_in;

      ok2_ff    <= ok2_in;
      adj2_ff   <= adj2_in;
      yb2_ff    <= yb2_in;
      qyb2_ff   <= qyb2_in;
      month2_ff <= month1_ff;
      day2_ff   <= day1_ff;
      tod2_ff   <= tod1_ff;

      ok3_ff    <= ok2_ff;
      days3_ff  <= days3_in;
      tod3_ff   <= tod2_ff;

      ok4_ff    <= ok3_ff;
      days4_ff  <= days3_ff;
      tod4_ff   <= tod3_ff;
      dms4_ff   <= dms4_in;
      wprod4_ff <= wprod4_in;
   end

   // Last two stages: ms times the tick rate.
   cdt_tick_mul #(
      .TICKS_PER_MS(TICKS_PER_MS)
   ) u_tick_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_ms     (ms5_in),
      .in_side   (side5_in),
      .out_valid (rsp_strobe),
      .out_tick  (rsp_tick_count),
      .out_side  (side_out)
   );

   assign rsp_is_valid  = side_out.is_valid;
   assign rsp_day_count = side_out.day_count;
   assign rsp_weekday   = side_out.weekday;

   // Every item taken gives a result after the pipeline latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_strobe)
      else $error("item taken but no result after the pipeline latency");

   // No result appears without an item taken one pipeline latency earlier.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without a matching item");

   // An out-of-range item gives zero counts and weekday.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_is_valid |-> (rsp_tick_count == '0) && (rsp_day_count == '0)
                                      && (rsp_weekday == '0))
      else $error("invalid item with nonzero counts");

   // The weekday correction must land below seven.
   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_weekday < cdt_pkg::DAYS_PER_WEEK)
      else $error("weekday out of range");

endmodule

// File: rtl/core/cdt_tick_mul.sv
// Two-stage multiply of the millisecond count by the tick rate, with sideband carried along.
// Depends on cdt_pkg for widths and the sideband type.
`timescale 1ns / 1ps

module cdt_tick_mul #(
   parameter int TICKS_PER_MS = 10000
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [cdt_pkg::MS_W-1:0]  in_ms,
   input  cdt_pkg::cdt_side_type     in_side,
   output logic                      out_valid,
   output logic [cdt_pkg::TICK_W-1:0] out_tick,
   output cdt_pkg::cdt_side_type     out_side
);

   localparam int TPM_W = $clog2(TICKS_PER_MS + 1);
   localparam int LO_W  = cdt_pkg::MS_LO_W + TPM_W;
   localparam int HI_W  = cdt_pkg::MS_HI_W + TPM_W;

   logic [TPM_W-1:0] rate;
   logic [LO_W-1:0]  lo_in, lo_ff;
   logic [HI_W-1:0]  hi_in, hi_ff;
   logic             valid_a_ff, valid_b_ff;
   cdt_pkg::cdt_side_type side_a_ff, side_b_ff;
   logic [cdt_pkg::SUM_W-1:0]  tick_sum;
   logic [cdt_pkg::TICK_W-1:0] tick_ff;

   assign rate = TPM_W'(TICKS_PER_MS);

   // First stage: two narrow partial products of the split millisecond count.
   assign lo_in = LO_W'(in_ms[cdt_pkg::MS_LO_W-1:0]) * LO_W'(rate);
   assign hi_in = HI_W'(in_ms[cdt_pkg::MS_W-1:cdt_pkg::MS_LO_W]) * HI_W'(rate);

   // Second stage: recombine the partial products into the tick count.
   assign tick_sum = cdt_pkg::SUM_W'({hi_ff, {cdt_pkg::MS_LO_W{1'b0}}})
                   + cdt_pkg::SUM_W'(lo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      side_a_ff <= in_side;
      tick_ff   <= tick_sum[cdt_pkg::TICK_W-1:0];
      side_b_ff <= side_a_ff;
   end

   assign out_valid = valid_b_ff;
   assign out_tick  = tick_ff;
   assign out_side  = side_b_ff;

endmodule

// File: tb/datetime_tick_checker.sv
// Checker for civil_datetime_to_ticks: watches the request and result channels, predicts
// each result from the accepted item and compares it field by field. Depends on cdt_pkg.
`timescale 1ns / 1ps

module datetime_tick_checker #(
   parameter int TICKS_PER_MS = 10000
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [cdt_pkg::YEAR_W-1:0]   req_year_in,
   input  logic [cdt_pkg::MONTH_W-1:0]  req_month_in,
   input  logic [cdt_pkg::DAY_IN_W-1:0] req_day_in,
   input  logic [cdt_pkg::HOUR_W-1:0]   req_hour_in,
   input  logic [cdt_pkg::MINUTE_W-1:0] req_minute_in,
   input  logic [cdt_pkg::SECOND_W-1:0] req_second_in,
   input  logic [cdt_pkg::MILLI_W-1:0]  req_milli_in,
   input  logic                         rsp_strobe,
   input  logic                         rsp_is_valid,
   input  logic [cdt_pkg::TICK_W-1:0]   rsp_tick_count,
   input  logic [cdt_pkg::DAY_W-1:0]    rsp_day_count,
   input  logic [cdt_pkg::WDAY_W-1:0]   rsp_weekday,
   output int                           fail_count,
   output int                           pending_count,
   output int                           checked_count,
   output int                           in_range_count
);

   // One predicted conversion result.
   typedef struct packed {
      logic                         in_range;
      logic [cdt_pkg::TICK_W-1:0]   ticks;
      logic [cdt_pkg::DAY_W-1:0]    days;
      logic [cdt_pkg::WDAY_W-1:0]   wday;
   } tick_result_type;

   tick_result_type pending_conversions[$];

   int fails     = 0;
   int waiting   = 0;
   int checked   = 0;
   int in_range  = 0;

   assign fail_count     = fails;
   assign pending_count  = waiting;
   assign checked_count  = checked;
   assign in_range_count = in_range;

   // Computes the expected result for one date and time of day.
   function automatic tick_result_type convert_datetime(
      input logic [cdt_pkg::YEAR_W-1:0]   year,
      input logic [cdt_pkg::MONTH_W-1:0]  month,
      input logic [cdt_pkg::DAY_IN_W-1:0] day,
      input logic [cdt_pkg::HOUR_W-1:0]   hour,
      input logic [cdt_pkg::MINUTE_W-1:0] minute,
      input logic [cdt_pkg::SECOND_W-1:0] second,
      input logic [cdt_pkg::MILLI_W-1:0]  milli
   );
      tick_result_type res;
      logic [63:0]  yb;
      logic [63:0]  days;
      logic [63:0]  ms;
      logic [63:0]  before_month;
      int unsigned  mlen;
      bit           leap;
      bit           ok;
      res  = '0;
      leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
      ok   = (year >= 1) && (year <= 9999) && (month >= 1) && (month <= 12);
      // Month length, with February stretched in leap years.
      case (month)
         4'd2:                      mlen = leap ? 29 : 28;
         4'd4, 4'd6, 4'd9, 4'd11:   mlen = 30;
         default:                   mlen = 31;
      endcase
      if (ok && ((day < 1) || (day > mlen))) ok = 1'b0;
      if ((hour > 23) || (minute > 59) || (second > 59) || (milli > 999)) ok = 1'b0;
      if (!ok) return res;
      // Days in the months before this one, common year.
      case (month)
         4'd1:    before_month = 0;
         4'd2:    before_month = 31;
         4'd3:    before_month = 59;
         4'd4:    before_month = 90;
         4'd5:    before_month = 120;
         4'd6:    before_month = 151;
         4'd7:    before_month = 181;
         4'd8:    before_month = 212;
         4'd9:    before_month = 243;
         4'd10:   before_month = 273;
         4'd11:   before_month = 304;
         default: before_month = 334;
      endcase
      yb   = 64'(year) - 64'd1;
      days = yb * 365 + yb / 4 - yb / 100 + yb / 400 + before_month + 64'(day) - 64'd1;
      if ((month > 2) && leap) days = days + 1;
      ms = days * 64'd86400000 + 64'(hour) * 64'd3600000 + 64'(minute) * 64'd60000
         + 64'(second) * 64'd1000 + 64'(milli);
      res.in_range = 1'b1;
      res.ticks    = cdt_pkg::TICK_W'(ms * 64'(TICKS_PER_MS));
      res.days     = cdt_pkg::DAY_W'(days);
      res.wday     = cdt_pkg::WDAY_W'(days % 7);
      return res;
   endfunction

   // Retire a result against the oldest prediction, then record the item taken this edge.
   always @(posedge clock) begin
      tick_result_type want;
      int           errs;
      errs = 0;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (pending_conversions.size() == 0) begin
               $display("%0t: result with no item waiting (valid %0b ticks %0d)",
                        $time, rsp_is_valid, rsp_tick_count);
               errs++;
            end else begin
               want = pending_conversions.pop_front();
               if (rsp_is_valid !== want.in_range) begin
                  $display("%0t: is_valid expected %0b got %0b",
                           $time, want.in_range, rsp_is_valid);
                  errs++;
               end
               if (rsp_tick_count !== want.ticks) begin
                  $display("%0t: tick_count expected %0d got %0d",
                           $time, want.ticks, rsp_tick_count);
                  errs++;
               end
               if (rsp_day_count !== want.days) begin
                  $display("%0t: day_count expected %0d got %0d",
                           $time, want.days, rsp_day_count);
                  errs++;
               end
               if (rsp_weekday !== want.wday) begin
                  $display("%0t: weekday expected %0d got %0d",
                           $time, want.wday, rsp_weekday);
                  errs++;
               end
            end
         end
         if ((start === 1'b1) && (busy === 1'b0)) begin
            want = convert_datetime(req_year_in, req_month_in, req_day_in, req_hour_in,
                                    req_minute_in, req_second_in, req_milli_in);
            pending_conversions.push_back(want);
            checked  <= checked + 1;
            in_range <= in_range + int'(want.in_range);
         end
      end
      fails   <= fails + errs;
      waiting <= pending_conversions.size();
   end

endmodule

// File: tb/tb_top.sv
// Testbench top for civil_datetime_to_ticks: drives directed and random date items and
// gives the verdict. Depends on cdt_pkg, the block and datetime_tick_checker.
`timescale 1ns / 1ps

module tb_top;

   localparam int TICKS_PER_MS = 10000;
   localparam int ITEMS_PER_PHASE = 367;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [cdt_pkg::YEAR_W-1:0]   req_year_in   = '0;
   logic [cdt_pkg::MONTH_W-1:0]  req_month_in  = '0;
   logic [cdt_pkg::DAY_IN_W-1:0] req_day_in    = '0;
   logic [cdt_pkg::HOUR_W-1:0]   req_hour_in   = '0;
   logic [cdt_pkg::MINUTE_W-1:0] req_minute_in = '0;
   logic [cdt_pkg::SECOND_W-1:0] req_second_in = '0;
   logic [cdt_pkg::MILLI_W-1:0]  req_milli_in  = '0;
   logic                         rsp_strobe;
   logic                         rsp_is_valid;
   logic [cdt_pkg::TICK_W-1:0]   rsp_tick_count;
   logic [cdt_pkg::DAY_W-1:0]    rsp_day_count;
   logic [cdt_pkg::WDAY_W-1:0]   rsp_weekday;

   int fail_count;
   int pending_count;
   int checked_count;
   int in_range_count;
   int idle_pct = 0;

   // Free-running clock, 12 ns period.
   always #6 clock = ~clock;

   civil_datetime_to_ticks #(.TICKS_PER_MS(TICKS_PER_MS)) dut (
      .clock, .reset, .start, .busy,
      .req_year_in, .req_month_in, .req_day_in, .req_hour_in,
      .req_minute_in, .req_second_in, .req_milli_in,
      .rsp_strobe, .rsp_is_valid, .rsp_tick_count, .rsp_day_count, .rsp_weekday
   );

   datetime_tick_checker #(.TICKS_PER_MS(TICKS_PER_MS)) u_checker (
      .clock, .reset, .start, .busy,
      .req_year_in, .req_month_in, .req_day_in, .req_hour_in,
      .req_minute_in, .req_second_in, .req_milli_in,
      .rsp_strobe, .rsp_is_valid, .rsp_tick_count, .rsp_day_count, .rsp_weekday,
      .fail_count, .pending_count, .checked_count, .in_range_count
   );

   // Offers one item at a falling edge, after random idle cycles, and holds it until taken.
   task automatic send_item(input int y, input int mo, input int d, input int h,
                            input int mi, input int s, input int ms);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start         <= 1'b1;
      req_year_in   <= cdt_pkg::YEAR_W'(y);
      req_month_in  <= cdt_pkg::MONTH_W'(mo);
      req_day_in    <= cdt_pkg::DAY_IN_W'(d);
      req_hour_in   <= cdt_pkg::HOUR_W'(h);
      req_minute_in <= cdt_pkg::MINUTE_W'(mi);
      req_second_in <= cdt_pkg::SECOND_W'(s);
      req_milli_in  <= cdt_pkg::MILLI_W'(ms);
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // Stimulus: reset, directed corners, then three random phases.
   initial begin
      int y, mo, d, h, mi, s, ms;
      int kind;
      int guard;
      int leftover;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // First and last representable instants, then range edges of each field.
      send_item(1, 1, 1, 0, 0, 0, 0);
      send_item(9999, 12, 31, 23, 59, 59, 999);
      send_item(0, 1, 1, 0, 0, 0, 0);
      send_item(10000, 1, 1, 0, 0, 0, 0);
      send_item(16383, 15, 31, 31, 63, 63, 1023);
      send_item(2024, 0, 1, 0, 0, 0, 0);
      send_item(2024, 13, 1, 0, 0, 0, 0);
      send_item(2024, 3, 0, 0, 0, 0, 0);
      send_item(2024, 24 - 12, 31, 24, 0, 0, 0);
      send_item(2024, 6, 15, 23, 60, 0, 0);
      send_item(2024, 6, 15, 12, 30, 60, 0);
      send_item(2024, 6, 15, 12, 30, 30, 1000);
      send_item(2024, 6, 15, 12, 59, 59, 999);
      // Leap-year rule: by 4, not by 100, unless by 400.
      send_item(2000, 2, 29, 1, 2, 3, 4);
      send_item(2024, 2, 29, 0, 0, 0, 0);
      send_item(1900, 2, 29, 0, 0, 0, 0);
      send_item(2023, 2, 29, 0, 0, 0, 0);
      send_item(1900, 2, 28, 23, 59, 59, 999);
      send_item(2000, 3, 1, 0, 0, 0, 0);
      send_item(1900, 3, 1, 0, 0, 0, 0);
      send_item(2024, 2, 30, 0, 0, 0, 0);
      // Thirty-day month past its end, and its last day.
      send_item(2023, 4, 31, 0, 0, 0, 0);
      send_item(2023, 4, 30, 0, 0, 0, 0);
      send_item(9999, 12, 32 - 1, 23, 59, 59, 1000);

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 19 : (phase == 1) ? 69 : 0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Mostly well-formed dates, with near-extreme years now and then.
            if ($urandom_range(9) == 0)
               y = $urandom_range(1) ? $urandom_range(1, 12) : $urandom_range(9988, 9999);
            else
               y = $urandom_range(1, 9999);
            mo = $urandom_range(1, 12);
            d  = ($urandom_range(3) == 0) ? $urandom_range(28, 31) : $urandom_range(1, 28);
            h  = $urandom_range(0, 23);
            mi = $urandom_range(0, 59);
            s  = $urandom_range(0, 59);
            ms = $urandom_range(0, 999);
            kind = $urandom_range(99);
            if (kind >= 85) begin
               // Raw noise over every field.
               y  = $urandom;
               mo = $urandom;
               d  = $urandom;
               h  = $urandom;
               mi = $urandom;
               s  = $urandom;
               ms = $urandom;
            end else if (kind >= 70) begin
               // A single field pushed out of range.
               case ($urandom_range(6))
                  0: y  = $urandom_range(1) ? 0 : $urandom_range(10000, 16383);
                  1: mo = $urandom_range(1) ? 0 : $urandom_range(13, 15);
                  2: d  = 0;
                  3: h  = $urandom_range(24, 31);
                  4: mi = $urandom_range(60, 63);
                  5: s  = $urandom_range(60, 63);
                  default: ms = $urandom_range(1000, 1023);
               endcase
            end
            send_item(y, mo, d, h, mi, s, ms);
         end
      end
      @(negedge clock);
      start <= 1'b0;

      // Drain the pipeline, then a few more cycles for any stray result.
      guard = 0;
      while ((pending_count != 0) && (guard < 200)) begin
         @(posedge clock);
         guard++;
      end
      repeat (12) @(posedge clock);
      leftover = pending_count;
      if (leftover != 0)
         $display("%0t: %0d predicted results never arrived", $time, leftover);

      $display("Summary: %0d items converted and checked, %0d of them valid dates.",
               checked_count, in_range_count);
      $display("Covered field limits, leap rules and sender idle rates of 19, 69 and 0 pct.");
      if ((fail_count + leftover) == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Watchdog for a hung run.
   initial begin
      #5000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: files.f
rtl/core/cdt_pkg.sv
rtl/core/cdt_tick_mul.sv
rtl/core/civil_datetime_to_ticks.sv
tb/datetime_tick_checker.sv
tb/tb_top.sv
